FILE: hdl/b64d_pkg.sv
// Shared types and constants for the base64url decoder.
`default_nettype none
package b64d_pkg;

  // Special characters of the URL-safe alphabet
  localparam logic [7:0] CharPad   = 8'h3d;  // '='
  localparam logic [7:0] CharDash  = 8'h2d;  // '-'
  localparam logic [7:0] CharUnder = 8'h5f;  // '_'

  localparam logic [1:0] TailSat = 2'd3;

  // Input beat
  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_string;
  } in_t;

  // Result beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_status;
    logic       decode_error;
    logic       last;
  } out_t;

  // Work passed from front to back: up to three bytes, then maybe a status beat
  typedef struct packed {
    logic [23:0] bytes;   // left aligned, first byte in [23:16]
    logic [1:0]  nbytes;
    logic        status;
    logic        err;
  } job_t;

endpackage
`default_nettype wire

FILE: hdl/b64d_front.sv
// Front end: classifies characters, tracks group and tail state, builds jobs.
`default_nettype none
module b64d_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          accept_i,
  input  wire b64d_pkg::in_t in_data_i,
  output b64d_pkg::job_t     job_o,
  output logic               job_push_o
);
  import b64d_pkg::*;

  logic [17:0] buf_q, buf_d;
  logic [1:0]  gc_q, gc_d;
  logic [1:0]  tl_q, tl_d;
  logic        bad_q, bad_d;

  logic       is_alpha;
  logic [5:0] sext;
  logic [7:0] c;
  logic [23:0] word;
  logic        err;

  assign c = in_data_i.char_code;

  // Character to sextet
  always_comb begin
    is_alpha = 1'b1;
    sext     = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      sext = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      sext = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      sext = 6'(c - 8'h30 + 8'd52);
    end else if (c == CharDash) begin
      sext = 6'd62;
    end else if (c == CharUnder) begin
      sext = 6'd63;
    end else begin
      is_alpha = 1'b0;
    end
  end

  assign word = {buf_q, sext};

  // State update and job build
  always_comb begin
    buf_d      = buf_q;
    gc_d       = gc_q;
    tl_d       = tl_q;
    bad_d      = bad_q;
    job_o      = '0;
    err        = 1'b0;
    if (accept_i) begin
      if (tl_q == 2'd0 && is_alpha) begin
        if (gc_q == 2'd3) begin
          job_o.bytes  = word;
          job_o.nbytes = 2'd3;
          buf_d        = '0;
          gc_d         = 2'd0;
        end else begin
          buf_d = word[17:0];
          gc_d  = gc_q + 2'd1;
        end
      end else begin
        if (tl_q != TailSat) tl_d = tl_q + 2'd1;
        if (c != CharPad) bad_d = 1'b1;
      end
      if (in_data_i.end_of_string) begin
        err = bad_d | (tl_d == TailSat);
        // trailing partial group
        if (!err) begin
          case (gc_d)
            2'd2: begin
              job_o.bytes  = {buf_d[11:4], 16'h0000};
              job_o.nbytes = 2'd1;
            end
            2'd3: begin
              job_o.bytes  = {buf_d[17:10], buf_d[9:2], 8'h00};
              job_o.nbytes = 2'd2;
            end
            default: ;
          endcase
        end
        job_o.status = 1'b1;
        job_o.err    = err;
        buf_d = '0;
        gc_d  = '0;
        tl_d  = '0;
        bad_d = 1'b0;
      end
    end
  end

  assign job_push_o = accept_i && (job_o.nbytes != 2'd0 || job_o.status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      gc_q  <= '0;
      tl_q  <= '0;
      bad_q <= 1'b0;
    end else begin
      buf_q <= buf_d;
      gc_q  <= gc_d;
      tl_q  <= tl_d;
      bad_q <= bad_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/b64d_fifo.sv
// Small register queue of jobs between front and back.
`default_nettype none
module b64d_fifo #(
  parameter int unsigned Depth = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_i,
  input  wire b64d_pkg::job_t wr_data_i,
  output logic                full_o,
  input  wire logic           rd_i,
  output b64d_pkg::job_t      rd_data_o,
  output logic                empty_o
);
  import b64d_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == CntFull);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rp_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= (wp_q == PtrMax) ? '0 : wp_q + PtrW'(1);
      if (do_rd) rp_q <= (rp_q == PtrMax) ? '0 : rp_q + PtrW'(1);
      if (do_wr && !do_rd) cnt_q <= cnt_q + CntW'(1);
      else if (do_rd && !do_wr) cnt_q <= cnt_q - CntW'(1);
    end
  end

endmodule
`default_nettype wire

FILE: hdl/b64d_back.sv
// Back end: walks each job out as result beats through an output register.
`default_nettype none
module b64d_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire b64d_pkg::job_t job_i,
  input  wire logic           job_avail_i,
  output logic                job_pop_o,
  output b64d_pkg::out_t      out_data_o,
  output logic                out_valid_o,
  input  wire logic           out_take_i
);
  import b64d_pkg::*;

  job_t cur_q, cur_d;
  logic cur_valid_q, cur_valid_d;
  out_t out_q, out_d;
  logic out_valid_q, out_valid_d;

  out_t beat;
  logic advance, beat_last, cur_free;

  // Current beat of the job
  always_comb begin
    beat = '0;
    if (cur_q.nbytes != 2'd0) begin
      beat.data_byte = cur_q.bytes[23:16];
    end else begin
      beat.is_status    = 1'b1;
      beat.decode_error = cur_q.err;
      beat.last         = 1'b1;
    end
  end

  assign advance   = cur_valid_q && (!out_valid_q || out_take_i);
  assign beat_last = (cur_q.nbytes == 2'd0) ||
                     (cur_q.nbytes == 2'd1 && !cur_q.status);
  assign cur_free  = !cur_valid_q || (advance && beat_last);
  assign job_pop_o = cur_free && job_avail_i;

  // Job register and output register
  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_take_i;
    if (advance) begin
      out_d        = beat;
      out_valid_d  = 1'b1;
      cur_d.bytes  = {cur_q.bytes[15:0], 8'h00};
      cur_d.nbytes = (cur_q.nbytes != 2'd0) ? cur_q.nbytes - 2'd1 : 2'd0;
    end
    if (cur_free) begin
      cur_valid_d = job_avail_i;
      cur_d       = job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    out_q <= out_d;
  end

  assign out_data_o  = out_q;
  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: hdl/base64url_decoder_top.sv
// Top level of the streaming base64url decoder.
// Path: each job passes through the job queue, then the job register, then the output register.
// Throughput: one character per cycle and one result beat per cycle; a full group
// of four characters yields three byte beats, so input keeps pace unless the job queue
// (QueueDepth entries) fills while the result side stalls.
// Reset: rst_ni clears group, tail, queue and output state; the first string starts clean.
`default_nettype none
module base64url_decoder_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire b64d_pkg::in_t  in_data_i,
  output logic                empty,
  input  wire logic           pop,
  output b64d_pkg::out_t      out_data_o
);
  import b64d_pkg::*;

  job_t job_in, job_out;
  logic job_push, job_pop, q_empty, q_full, accept, out_valid;

  assign full   = q_full;
  assign accept = push && !q_full;
  assign empty  = !out_valid;

  b64d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .job_o      (job_in),
    .job_push_o (job_push)
  );

  b64d_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (job_push),
    .wr_data_i (job_in),
    .full_o    (q_full),
    .rd_i      (job_pop),
    .rd_data_o (job_out),
    .empty_o   (q_empty)
  );

  b64d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job_out),
    .job_avail_i (!q_empty),
    .job_pop_o   (job_pop),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid),
    .out_take_i  (pop)
  );

endmodule
`default_nettype wire

FILE: tb/sv/base64url_decoder_top_test.sv
// Self-checking testbench for the streaming base64url decoder top level.
`timescale 1ns / 1ps
module base64url_decoder_top_test;
  import b64d_pkg::*;

  localparam int IdleLimit    = 3000;  // cycles without any accepted beat
  localparam int StallCycles  = 60;    // long receiver hold-off
  localparam int SettleCycles = 20;    // quiet time after the last result

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic push   = 1'b0;
  logic pop    = 1'b0;
  in_t  in_data_i = '0;
  logic full;
  logic empty;
  out_t out_data_o;

  base64url_decoder_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  // Clock, then reset released on a falling clock edge
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Stimulus and checking bookkeeping
  in_t  pending_chars[$];
  out_t expected_beats[$];
  out_t want_beat;
  int   chars_queued  = 0;
  int   mismatches    = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  logic stall_request = 1'b0;
  logic stall_done;
  int   hold_left;
  int   quiet_cycles  = 0;

  // Decoder state as predicted
  logic [17:0] grp_bits      = '0;
  logic [1:0]  grp_len       = '0;
  logic [1:0]  tail_len      = '0;
  logic        tail_has_junk = 1'b0;

  function automatic int sextet_value(logic [7:0] c);
    if (c >= "A" && c <= "Z") return int'(c - "A");
    if (c >= "a" && c <= "z") return int'(c - "a") + 26;
    if (c >= "0" && c <= "9") return int'(c - "0") + 52;
    if (c == CharDash) return 62;
    if (c == CharUnder) return 63;
    return -1;
  endfunction

  function automatic logic [7:0] alphabet_char(int s);
    if (s < 26) return 8'("A" + s);
    if (s < 52) return 8'("a" + s - 26);
    if (s < 62) return 8'("0" + s - 52);
    if (s == 62) return CharDash;
    return CharUnder;
  endfunction

  function automatic out_t data_beat(logic [7:0] b);
    out_t beat;
    beat = '0;
    beat.data_byte = b;
    return beat;
  endfunction

  // Append one beat to the expected results
  task automatic expect_beat(input out_t b);
    expected_beats = {expected_beats, b};
  endtask

  // Advance the predicted decoder by one character, queue the beats it yields
  task automatic decode_char(input in_t ch);
    int          v;
    logic [23:0] word;
    out_t        status;
    logic        bad;
    v = sextet_value(ch.char_code);
    if (tail_len == 0 && v >= 0) begin
      word = {grp_bits, 6'(v)};
      if (grp_len == 2'd3) begin
        expect_beat(data_beat(word[23:16]));
        expect_beat(data_beat(word[15:8]));
        expect_beat(data_beat(word[7:0]));
        grp_bits = '0;
        grp_len  = '0;
      end else begin
        grp_bits = word[17:0];
        grp_len  = grp_len + 2'd1;
      end
    end else begin
      if (tail_len != TailSat) tail_len = tail_len + 2'd1;
      if (ch.char_code != CharPad) tail_has_junk = 1'b1;
    end

    // Close the string: flush a partial group, then the status beat
    if (ch.end_of_string) begin
      bad = tail_has_junk || (tail_len == TailSat);
      if (!bad) begin
        if (grp_len == 2'd2) begin
          expect_beat(data_beat(grp_bits[11:4]));
        end else if (grp_len == 2'd3) begin
          expect_beat(data_beat(grp_bits[17:10]));
          expect_beat(data_beat(grp_bits[9:2]));
        end
      end
      status = '0;
      status.is_status    = 1'b1;
      status.decode_error = bad;
      status.last         = 1'b1;
      expect_beat(status);
      grp_bits      = '0;
      grp_len       = '0;
      tail_len      = '0;
      tail_has_junk = 1'b0;
    end
  endtask

  task automatic add_char(logic [7:0] c, logic last_char);
    in_t ch;
    ch.char_code     = c;
    ch.end_of_string = last_char;
    pending_chars = {pending_chars, ch};
    chars_queued++;
  endtask

  task automatic add_text(string s, logic closes);
    for (int i = 0; i < s.len(); i++) add_char(s[i], closes && (i == s.len() - 1));
  endtask

  // Mostly well-formed strings with random content, some noise
  task automatic add_random_string();
    logic [7:0] txt[$];
    int kind;
    int groups;
    int rest;
    int pick;
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
      rest = $urandom_range(0, 3);
      if (groups == 0 && rest == 0) rest = $urandom_range(1, 3);
      repeat (groups * 4 + rest) txt = {txt, alphabet_char($urandom_range(0, 63))};
      repeat ($urandom_range(0, 2)) txt = {txt, CharPad};
    end else begin
      repeat ($urandom_range(1, 6)) begin
        pick = $urandom_range(0, 3);
        if (pick < 2) txt = {txt, alphabet_char($urandom_range(0, 63))};
        else if (pick == 2) txt = {txt, CharPad};
        else txt = {txt, 8'($urandom_range(0, 255))};
      end
    end
    foreach (txt[i]) add_char(txt[i], i == txt.size() - 1);
  endtask

  task automatic fill_random(int upto);
    while (chars_queued < upto) add_random_string();
  endtask

  task automatic wait_sent();
    while (pending_chars.size() != 0 || push) @(negedge clk_i);
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // Sequence of phases
  initial begin
    wait (rst_ni);
    @(negedge clk_i);
    send_idle_pct = 14;
    recv_idle_pct = 69;

    // Directed strings
    add_text("_-__", 1'b1);      // top sextets, dash and underscore
    add_text("A", 1'b1);         // single trailing sextet
    add_text("Az0=", 1'b1);      // one pad, two bytes out
    add_text("9A==", 1'b1);      // two pads, one byte out
    add_text("A===", 1'b1);      // tail too long
    add_text("AB", 1'b0);        // non-alphabet byte starts the tail
    add_char(8'hff, 1'b1);
    add_char(8'h00, 1'b1);       // string made of a foreign byte only
    add_text("Za9", 1'b1);       // three-sextet group, no pad
    add_text("Q=B", 1'b1);       // alphabet after the tail started

    fill_random(120);
    wait_sent();
    send_idle_pct = 69;
    recv_idle_pct = 14;
    fill_random(240);
    wait_sent();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request = 1'b1;
    fill_random(360);
    wait_sent();

    while (expected_beats.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("base64url_decoder_top_test: done, clean");
    end else begin
      $display("base64url_decoder_top_test: done, errors");
    end
    $finish;
  end

  // Driver: offer pending characters, predict on each accepted beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (push && !full) decode_char(in_data_i);
      if (!push || !full) begin
        if (pending_chars.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          push      <= 1'b1;
          in_data_i <= pending_chars.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop        <= 1'b0;
      hold_left  <= 0;
      stall_done <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: %p", out_data_o);
          mismatches++;
        end else begin
          want_beat = expected_beats.pop_front();
          check_field("data_byte", want_beat.data_byte, out_data_o.data_byte);
          check_field("is_status", want_beat.is_status, out_data_o.is_status);
          check_field("decode_error", want_beat.decode_error, out_data_o.decode_error);
          check_field("last", want_beat.last, out_data_o.last);
        end
      end
      // One long hold-off so the input side backs up
      if (stall_request && !stall_done) begin
        stall_done <= 1'b1;
        hold_left  <= StallCycles;
        pop        <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        pop       <= 1'b0;
      end else begin
        pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog on cycles without progress
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= IdleLimit) begin
        $display("base64url_decoder_top_test: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

endmodule
